### rtl/core/lfa_pkg.sv
`timescale 1ns / 1ps

package lfa_pkg;

    localparam int ID_W     = 11;
    localparam int ID_LIMIT = 2047;
    localparam int WORD_W   = 32;
    localparam int WORD_LOG = 5;

    localparam logic OP_TAKE   = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [WORD_LOG-1:0] t_bit;

    typedef struct packed {
        logic found;
        t_bit idx;
    } t_enc;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RET_RD,
        ST_RET_MOD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } t_state;

endpackage

### rtl/core/lfa_req_if.sv
`timescale 1ns / 1ps

interface lfa_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    lfa_pkg::t_id returned_id;

    modport source (output valid, output operation, output returned_id, input ready);
    modport sink   (input valid, input operation, input returned_id, output ready);
endinterface

### rtl/core/lfa_rsp_if.sv
`timescale 1ns / 1ps

interface lfa_rsp_if;
    logic         valid;
    logic         ready;
    lfa_pkg::t_id given_id;
    logic         exhausted;

    modport source (output valid, output given_id, output exhausted, input ready);
    modport sink   (input valid, input given_id, input exhausted, output ready);
endinterface

### rtl/core/lfa_map_ram.sv
`timescale 1ns / 1ps

module lfa_map_ram #(
    parameter int ROWS   = 32,
    parameter int ROW_AW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ROW_AW-1:0]     i_waddr,
    input  lfa_pkg::t_word        i_wdata,
    input  logic                  i_re,
    input  logic [ROW_AW-1:0]     i_raddr,
    output lfa_pkg::t_word        o_rdata
);

    lfa_pkg::t_word r_mem [ROWS];
    lfa_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lfa_lsb_enc.sv
`timescale 1ns / 1ps

module lfa_lsb_enc (
    input  lfa_pkg::t_word i_word,
    output lfa_pkg::t_enc  o_enc
);

    always_comb begin
        o_enc.found = |i_word;
        o_enc.idx   = '0;
        for (int i = lfa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_enc.idx = lfa_pkg::t_bit'(i);
            end
        end
    end

endmodule

### rtl/core/lowest_free_id_allocator.sv
`timescale 1ns / 1ps

// Hands out the lowest free ID in 1..ID_COUNT. Given-back IDs are held in a
// one-bit-per-ID map stored as 32-bit rows in a small RAM; IDs never handed
// out lie at or above a high-water mark. After reset the block clears the map
// RAM, one row a cycle, for all ceil(min(ID_COUNT, 2047) / 32) rows before it
// takes its first transfer. A return that is ignored is dropped with no map
// access; any other return reads its map row and then sets its bit there. A
// take served from the high-water mark, or one that reports exhaustion, goes
// straight to the output stage; a take served from the map scans the rows
// from the lowest with a single 32-bit lowest-set-bit encoder, one RAM read
// and one check per row, until it reaches the row of the lowest returned ID.
// A result waits in an output register while the next request is taken.
module lowest_free_id_allocator #(
    parameter int ID_COUNT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lfa_req_if.sink        i_req,
    lfa_rsp_if.source      o_rsp
);

    localparam int MapIds = (ID_COUNT < lfa_pkg::ID_LIMIT) ? ID_COUNT : lfa_pkg::ID_LIMIT;
    localparam int Rows   = (MapIds + lfa_pkg::WORD_W - 1) / lfa_pkg::WORD_W;
    localparam int RowAw  = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int HwW    = $clog2(ID_COUNT + 2);
    localparam int CntW   = $clog2(MapIds + 1);
    localparam int CmpW   = (HwW > lfa_pkg::ID_W) ? HwW : lfa_pkg::ID_W;

    typedef logic [RowAw-1:0] t_row;
    typedef logic [HwW-1:0]   t_hw;
    typedef logic [CntW-1:0]  t_cnt;
    typedef logic [CmpW-1:0]  t_cmp;

    lfa_pkg::t_state r_state, n_state;
    t_hw             r_hw, n_hw;
    t_cnt            r_cnt, n_cnt;
    t_row            r_row, n_row;
    lfa_pkg::t_bit   r_bit, n_bit;
    lfa_pkg::t_id    r_res_id, n_res_id;
    logic            r_res_ex, n_res_ex;
    logic            r_out_valid, n_out_valid;
    lfa_pkg::t_id    r_out_id, n_out_id;
    logic            r_out_ex, n_out_ex;

    logic            in_fire;
    logic            ret_ok;
    logic            out_free;
    lfa_pkg::t_id    ret_k;
    lfa_pkg::t_word  rd_data;
    lfa_pkg::t_enc   enc;
    logic            ram_we;
    logic            ram_re;
    lfa_pkg::t_word  ram_wdata;

    lfa_map_ram #(
        .ROWS   (Rows),
        .ROW_AW (RowAw)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_row),
        .o_rdata (rd_data)
    );

    lfa_lsb_enc u_lsb_enc (
        .i_word (rd_data),
        .o_enc  (enc)
    );

    assign i_req.ready = (r_state == lfa_pkg::ST_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign ret_k       = i_req.returned_id - lfa_pkg::t_id'(1);
    assign ret_ok      = (i_req.returned_id != '0)
                         && (t_cmp'(i_req.returned_id) < t_cmp'(r_hw));
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.given_id  = r_out_id;
    assign o_rsp.exhausted = r_out_ex;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfa_pkg::ST_CLEAR: begin
                if (r_row == t_row'(Rows - 1)) begin
                    n_state = lfa_pkg::ST_IDLE;
                end
            end
            lfa_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_req.operation == lfa_pkg::OP_RETURN) begin
                        n_state = ret_ok ? lfa_pkg::ST_RET_RD : lfa_pkg::ST_IDLE;
                    end else if (r_cnt != '0) begin
                        n_state = lfa_pkg::ST_SCAN_RD;
                    end else begin
                        n_state = lfa_pkg::ST_EMIT;
                    end
                end
            end
            lfa_pkg::ST_RET_RD:   n_state = lfa_pkg::ST_RET_MOD;
            lfa_pkg::ST_RET_MOD:  n_state = lfa_pkg::ST_IDLE;
            lfa_pkg::ST_SCAN_RD:  n_state = lfa_pkg::ST_SCAN_CHK;
            lfa_pkg::ST_SCAN_CHK: begin
                n_state = enc.found ? lfa_pkg::ST_EMIT : lfa_pkg::ST_SCAN_RD;
            end
            lfa_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = lfa_pkg::ST_IDLE;
                end
            end
            default: n_state = lfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_hw        = r_hw;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_bit       = r_bit;
        n_res_id    = r_res_id;
        n_res_ex    = r_res_ex;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_id    = r_out_id;
        n_out_ex    = r_out_ex;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = '0;
        unique case (r_state)
            lfa_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                n_row  = r_row + t_row'(1);
            end
            lfa_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_req.operation == lfa_pkg::OP_RETURN) begin
                        n_row = t_row'(ret_k >> lfa_pkg::WORD_LOG);
                        n_bit = lfa_pkg::t_bit'(ret_k);
                    end else if (r_cnt != '0) begin
                        n_row = '0;
                    end else if (r_hw <= t_hw'(ID_COUNT)) begin
                        n_res_id = lfa_pkg::t_id'(r_hw);
                        n_res_ex = 1'b0;
                        n_hw     = r_hw + t_hw'(1);
                    end else begin
                        n_res_id = '0;
                        n_res_ex = 1'b1;
                    end
                end
            end
            lfa_pkg::ST_RET_RD: begin
                ram_re = 1'b1;
            end
            lfa_pkg::ST_RET_MOD: begin
                ram_wdata = rd_data | (lfa_pkg::t_word'(1) << r_bit);
                if (!rd_data[r_bit]) begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + t_cnt'(1);
                end
            end
            lfa_pkg::ST_SCAN_RD: begin
                ram_re = 1'b1;
            end
            lfa_pkg::ST_SCAN_CHK: begin
                ram_wdata = rd_data & ~(lfa_pkg::t_word'(1) << enc.idx);
                if (enc.found) begin
                    ram_we   = 1'b1;
                    n_cnt    = r_cnt - t_cnt'(1);
                    n_res_id = lfa_pkg::t_id'({r_row, enc.idx}) + lfa_pkg::t_id'(1);
                    n_res_ex = 1'b0;
                end else begin
                    n_row = r_row + t_row'(1);
                end
            end
            lfa_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_res_id;
                    n_out_ex    = r_res_ex;
                end
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfa_pkg::ST_CLEAR;
            r_hw        <= t_hw'(1);
            r_cnt       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hw        <= n_hw;
            r_cnt       <= n_cnt;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit    <= n_bit;
        r_res_id <= n_res_id;
        r_res_ex <= n_res_ex;
        r_out_id <= n_out_id;
        r_out_ex <= n_out_ex;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(MapIds))
        else $error("returned-ID count exceeds the map size");

    a_hw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hw != '0) && (r_hw <= t_hw'(ID_COUNT + 1)))
        else $error("high-water mark out of range");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfa_pkg::ST_SCAN_CHK) && (r_row == t_row'(Rows - 1)) |-> enc.found)
        else $error("map scan ran past the last row without a returned ID");

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ex |-> (r_out_id == '0))
        else $error("exhausted result carries a nonzero ID");

endmodule

### tb/lfa_grant_checker.sv
`timescale 1ns / 1ps

module lfa_grant_checker #(
    parameter int ID_COUNT = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic         i_req_operation,
    input  lfa_pkg::t_id i_req_returned_id,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    input  lfa_pkg::t_id i_rsp_given_id,
    input  logic         i_rsp_exhausted,
    output int           o_fail_count,
    output int           o_pending_count
);

    typedef struct packed {
        lfa_pkg::t_id given_id;
        logic         exhausted;
    } t_grant;

    t_grant      grants_due[$];
    int unsigned fresh_mark = 1;
    bit          given_back[ID_COUNT];
    int unsigned given_back_count = 0;
    int          fail_count = 0;

    // Entry k of the map stands for ID k+1.
    function automatic t_grant take_lowest_free();
        t_grant g;
        g.given_id  = '0;
        g.exhausted = 1'b1;
        if (given_back_count != 0) begin
            for (int k = 0; k < ID_COUNT; k++) begin
                if (given_back[k]) begin
                    given_back[k]    = 1'b0;
                    given_back_count = given_back_count - 1;
                    g.given_id       = lfa_pkg::t_id'(k + 1);
                    g.exhausted      = 1'b0;
                    return g;
                end
            end
        end
        if (fresh_mark <= ID_COUNT) begin
            g.given_id  = lfa_pkg::t_id'(fresh_mark);
            g.exhausted = 1'b0;
            fresh_mark  = fresh_mark + 1;
        end
        return g;
    endfunction

    // IDs that were never handed out, zero and duplicates leave the map alone.
    function automatic void give_back(lfa_pkg::t_id id);
        if (id != '0 && id < fresh_mark && id <= ID_COUNT && !given_back[int'(id) - 1]) begin
            given_back[int'(id) - 1] = 1'b1;
            given_back_count         = given_back_count + 1;
        end
    endfunction

    task automatic note_mismatch(string what, t_grant want);
        fail_count = fail_count + 1;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected id %0d exhausted %0b, got id %0d exhausted %0b",
                     $time, what, want.given_id, want.exhausted,
                     i_rsp_given_id, i_rsp_exhausted);
        end
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            grants_due.delete();
            fresh_mark       = 1;
            given_back_count = 0;
            foreach (given_back[k]) begin
                given_back[k] = 1'b0;
            end
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (grants_due.size() == 0) begin
                    want = '0;
                    note_mismatch("grant with no request outstanding", want);
                end else begin
                    want = grants_due.pop_front();
                    if (want.given_id !== i_rsp_given_id || want.exhausted !== i_rsp_exhausted) begin
                        note_mismatch("grant mismatch", want);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_operation == lfa_pkg::OP_RETURN) begin
                    give_back(i_req_returned_id);
                end else begin
                    grants_due.push_back(take_lowest_free());
                end
            end
        end
        o_fail_count    <= fail_count;
        o_pending_count <= grants_due.size();
    end

endmodule

### tb/lowest_free_id_allocator_tb.sv
`timescale 1ns / 1ps

module lowest_free_id_allocator_tb;

    localparam int ID_COUNT         = 1024;
    localparam int RANDOM_ITEMS     = 1425;
    localparam int TAKE_HEAVY_ITEMS = 1200;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lfa_req_if req_ch();
    lfa_rsp_if rsp_ch();

    int           fail_count;
    int           pending_count;
    int           src_idle_pct    = 0;
    int           sink_stall_pct  = 0;
    int           takes_issued    = 0;
    lfa_pkg::t_id last_given_back = '0;

    lowest_free_id_allocator #(
        .ID_COUNT(ID_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lfa_grant_checker #(
        .ID_COUNT(ID_COUNT)
    ) u_grant_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (req_ch.valid),
        .i_req_ready       (req_ch.ready),
        .i_req_operation   (req_ch.operation),
        .i_req_returned_id (req_ch.returned_id),
        .i_rsp_valid       (rsp_ch.valid),
        .i_rsp_ready       (rsp_ch.ready),
        .i_rsp_given_id    (rsp_ch.given_id),
        .i_rsp_exhausted   (rsp_ch.exhausted),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_request(input logic op, input lfa_pkg::t_id id);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.returned_id <= id;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        if (op == lfa_pkg::OP_TAKE) begin
            takes_issued = takes_issued + 1;
        end else begin
            last_given_back = id;
        end
    endtask

    function automatic lfa_pkg::t_id pick_returned_id();
        int hi;
        hi = (takes_issued == 0) ? 1 : ((takes_issued > ID_COUNT) ? ID_COUNT : takes_issued);
        case ($urandom_range(9))
            6:       return last_given_back;
            7:       return '0;
            8:       return lfa_pkg::t_id'($urandom);
            9:       return lfa_pkg::t_id'($urandom_range(2047, ID_COUNT));
            default: return lfa_pkg::t_id'($urandom_range(hi, 1));
        endcase
    endfunction

    initial begin
        int take_pct;
        req_ch.valid       = 1'b0;
        req_ch.operation   = lfa_pkg::OP_TAKE;
        req_ch.returned_id = '0;
        i_rst_n            = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Give-backs of IDs never handed out, of zero and of duplicates must be ignored.
        send_request(lfa_pkg::OP_RETURN, 11'd1);
        send_request(lfa_pkg::OP_TAKE, '1);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_TAKE, 11'd5);
        send_request(lfa_pkg::OP_RETURN, '0);
        send_request(lfa_pkg::OP_RETURN, 11'd3);
        send_request(lfa_pkg::OP_RETURN, 11'd3);
        send_request(lfa_pkg::OP_RETURN, 11'd4);
        send_request(lfa_pkg::OP_RETURN, '1);
        send_request(lfa_pkg::OP_RETURN, 11'd1024);
        send_request(lfa_pkg::OP_RETURN, 11'd1);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_TAKE, '1);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_RETURN, 11'd7);
        send_request(lfa_pkg::OP_RETURN, 11'd2);
        send_request(lfa_pkg::OP_TAKE, '0);
        send_request(lfa_pkg::OP_TAKE, '0);

        // Takes dominate at first so that the pool runs dry before the mixed tail.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i * 4 / RANDOM_ITEMS)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 51;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 51;
                end
                default: begin
                    src_idle_pct   = 27;
                    sink_stall_pct = 27;
                end
            endcase
            take_pct = (i < TAKE_HEAVY_ITEMS) ? 93 : 50;
            if ($urandom_range(99) < take_pct) begin
                send_request(lfa_pkg::OP_TAKE, lfa_pkg::t_id'($urandom));
            end else begin
                send_request(lfa_pkg::OP_RETURN, pick_returned_id());
            end
        end
        req_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### lowest_free_id_allocator.f
rtl/core/lfa_pkg.sv
rtl/core/lfa_req_if.sv
rtl/core/lfa_rsp_if.sv
rtl/core/lfa_map_ram.sv
rtl/core/lfa_lsb_enc.sv
rtl/core/lowest_free_id_allocator.sv
tb/lfa_grant_checker.sv
tb/lowest_free_id_allocator_tb.sv
